/* sv/base64_stream_encoder_top_defines.svh */
`ifndef BASE64_STREAM_ENCODER_TOP_DEFINES_SVH
`define BASE64_STREAM_ENCODER_TOP_DEFINES_SVH

// same-cycle implication under the active-low synchronous reset
`define B64E_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64e check failed");

// next-cycle implication under the active-low synchronous reset
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64e check failed");

`endif

/* sv/b64e_pkg.sv */
`timescale 1ns / 1ps

package b64e_pkg;

  localparam logic [6:0] PAD_CHAR      = 7'd61;
  localparam logic [6:0] CHAR_UPPER_A  = 7'd65;
  localparam logic [6:0] LOWER_OFFSET  = 7'd71;
  localparam logic [6:0] DIGIT_OFFSET  = 7'd4;
  localparam logic [6:0] CHAR_PLUS     = 7'd43;
  localparam logic [6:0] CHAR_SLASH    = 7'd47;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_last;
  } b64e_in_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       run_last;
    logic       message_end;
  } b64e_out_t;

  // one classified byte: up to four characters, cnt is the index of the last one
  typedef struct packed {
    logic            last;
    logic [1:0]      cnt;
    logic [3:0][6:0] chars;
  } b64e_job_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] s);
    logic [6:0] c;
    c = 7'd0;
    if (s inside {[6'd0 : 6'd25]}) begin
      c = CHAR_UPPER_A + {1'b0, s};
    end else if (s inside {[6'd26 : 6'd51]}) begin
      c = LOWER_OFFSET + {1'b0, s};
    end else if (s inside {[6'd52 : 6'd61]}) begin
      c = {1'b0, s} - DIGIT_OFFSET;
    end else if (s == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

endpackage

/* sv/base64_stream_encoder_top.sv */
// the first character of a byte is written to a queue slot and then to the output register
// throughput: one character per cycle while the consumer pops; one to four characters per byte,
// sustained four characters per three bytes
// the character queue between classifier and emitter buffers QUEUE_DEPTH bytes
// reset (rst_n low, synchronous): group position, leftover bits, queue and output cleared
`timescale 1ns / 1ps

module base64_stream_encoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  b64e_pkg::b64e_in_t  in_data,
  output logic                empty,
  input  logic                pop,
  output b64e_pkg::b64e_out_t out_data
);
  import b64e_pkg::*;

  logic      job_valid;
  b64e_job_t job;
  logic      q_valid;
  logic      q_pop;
  b64e_job_t q_job;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job       (job)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (job_valid),
    .wr_job   (job),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  b64e_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

/* sv/b64e_front.sv */
`timescale 1ns / 1ps

module b64e_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic                full,
  input  b64e_pkg::b64e_in_t  in_data,
  output logic                job_valid,
  output b64e_pkg::b64e_job_t job
);
  import b64e_pkg::*;

  logic [1:0] pos_r, pos_nxt;
  logic [3:0] lo_r, lo_nxt;
  logic [1:0] pos_mid;
  logic [3:0] lo_mid;
  logic [7:0] b;

  assign job_valid = push && !full;
  assign b = in_data.data_byte;

  always_comb begin
    job.last  = in_data.message_last;
    job.cnt   = 2'd0;
    job.chars = {4{PAD_CHAR}};
    pos_mid   = POS_FIRST;
    lo_mid    = 4'd0;
    case (pos_r)
      POS_SECOND: begin
        job.chars[0] = sextet_char({lo_r[1:0], b[7:4]});
        lo_mid       = b[3:0];
        pos_mid      = POS_THIRD;
      end
      POS_THIRD: begin
        job.chars[0] = sextet_char({lo_r[3:0], b[7:6]});
        job.chars[1] = sextet_char(b[5:0]);
        job.cnt      = 2'd1;
      end
      default: begin
        job.chars[0] = sextet_char(b[7:2]);
        lo_mid       = {2'b00, b[1:0]};
        pos_mid      = POS_SECOND;
      end
    endcase

    pos_nxt = pos_mid;
    lo_nxt  = lo_mid;
    if (in_data.message_last) begin
      // flush leftover bits and pad to a full quad
      if (pos_mid == POS_SECOND) begin
        job.chars[1] = sextet_char({lo_mid[1:0], 4'b0000});
        job.cnt      = 2'd3;
      end else if (pos_mid == POS_THIRD) begin
        job.chars[1] = sextet_char({lo_mid[3:0], 2'b00});
        job.cnt      = 2'd2;
      end
      pos_nxt = POS_FIRST;
      lo_nxt  = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_FIRST;
      lo_r  <= 4'd0;
    end else if (job_valid) begin
      pos_r <= pos_nxt;
      lo_r  <= lo_nxt;
    end
  end

endmodule

/* sv/b64e_queue.sv */
`timescale 1ns / 1ps

module b64e_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  b64e_pkg::b64e_job_t wr_job,
  output logic                full,
  input  logic                rd_en,
  output logic                rd_valid,
  output b64e_pkg::b64e_job_t rd_job
);
  import b64e_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64e_job_t       slot_r [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW-1:0]   rp_r, rp_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != CW'(0));
  assign rd_job   = slot_r[rp_r];

  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    count_nxt = count_r;
    if (wr_en) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? AW'(0) : wp_r + AW'(1);
    end
    if (rd_en) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? AW'(0) : rp_r + AW'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CW'(1);
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= AW'(0);
      rp_r    <= AW'(0);
      count_r <= CW'(0);
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* sv/b64e_back.sv */
`timescale 1ns / 1ps

`include "base64_stream_encoder_top_defines.svh"

module b64e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  b64e_pkg::b64e_job_t q_job,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output b64e_pkg::b64e_out_t out_data
);
  import b64e_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  b64e_out_t  out_data_r, out_data_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       take;
  logic       emit;
  logic       run_end;

  assign take    = pop && out_valid_r;
  assign emit    = q_valid && (!out_valid_r || take);
  assign run_end = (idx_r == q_job.cnt);
  assign q_pop   = emit && run_end;
  assign empty   = !out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    idx_nxt       = idx_r;
    if (take) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.char_code   = q_job.chars[idx_r];
      out_data_nxt.run_last    = run_end;
      out_data_nxt.message_end = run_end && q_job.last;
      idx_nxt                  = run_end ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // beat index stays inside the head job
  `B64E_ASSERT_NOW(a_idx_in_job, clk, rst_n, q_valid, idx_r <= q_job.cnt)
  // no partial job left behind once the queue drains
  `B64E_ASSERT_NOW(a_idx_idle, clk, rst_n, !q_valid, idx_r == 2'd0)
  // message end only on the last beat of a byte
  `B64E_ASSERT_NOW(a_end_is_run_last, clk, rst_n, out_valid_r && out_data_r.message_end,
                   out_data_r.run_last)
  // a beat popped with no job waiting leaves the output empty
  `B64E_ASSERT_NEXT(a_drain, clk, rst_n, take && !q_valid, !out_valid_r)

endmodule
